[rtl/core/wbps_pkg.sv]
package wbps_pkg;

	// Fixed widths of the pattern registers and the result fields.
	localparam int REG_BYTES  = 16;
	localparam int LEN_W      = 5;
	localparam int COUNT_W    = 16;
	localparam int RES_OFF_W  = 32;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Register indexes, each register at byte address 8 * index.
	typedef enum logic [1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_WILDCARD     = 2'd2,
		REG_LENGTH       = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_AMBIGUOUS = 2'd2,
		STATUS_BAD       = 2'd3
	} status_t;

	typedef struct packed {
		logic [REG_BYTES-1:0][7:0] pattern;
		logic [REG_BYTES-1:0]      wildcard_mask;
		logic [LEN_W-1:0]          pattern_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		status_t              status;
		logic [RES_OFF_W-1:0] first_offset;
		logic [COUNT_W-1:0]   match_count;
	} out_t;

	// Outcome of the window compare for one byte.
	typedef struct packed {
		logic window_ok;
		logic bad;
	} match_t;

endpackage

[rtl/core/wbps_cfg_regs.sv]
module wbps_cfg_regs
	import wbps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [63:0]          pattern_low_q;
	logic [63:0]          pattern_high_q;
	logic [REG_BYTES-1:0] wildcard_q;
	logic [LEN_W-1:0]     length_q;
	reg_index_t           index;
	logic                 wr_en;

	assign index  = reg_index_t'(paddr[APB_ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			wildcard_q     <= '0;
			length_q       <= '0;
		end else if (wr_en) begin
			unique case (index)
				REG_PATTERN_LOW:  pattern_low_q  <= pwdata;
				REG_PATTERN_HIGH: pattern_high_q <= pwdata;
				REG_WILDCARD:     wildcard_q     <= pwdata[REG_BYTES-1:0];
				REG_LENGTH:       length_q       <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (index)
			REG_PATTERN_LOW:  prdata = pattern_low_q;
			REG_PATTERN_HIGH: prdata = pattern_high_q;
			REG_WILDCARD:     prdata = APB_DATA_W'(wildcard_q);
			REG_LENGTH:       prdata = APB_DATA_W'(length_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.pattern        = {pattern_high_q, pattern_low_q};
	assign cfg.wildcard_mask  = wildcard_q;
	assign cfg.pattern_length = length_q;

endmodule

[rtl/core/wbps_match.sv]
module wbps_match
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX = 16
) (
	input  logic [PATTERN_MAX-1:0][7:0] window,
	input  cfg_t                        cfg,
	output match_t                      match
);

	localparam int LEN_LIMIT = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;

	logic [LEN_LIMIT-1:0] byte_ok;
	logic                 all_wild;

	// Each pattern byte i lines up with the window byte len-1-i bytes back.
	always_comb begin
		logic       used;
		logic [7:0] sel;
		all_wild = 1'b1;
		for (int i = 0; i < LEN_LIMIT; i++) begin
			used = (i < int'(cfg.pattern_length));
			sel  = '0;
			for (int j = 0; j < PATTERN_MAX; j++) begin
				if (j == int'(cfg.pattern_length) - 1 - i) begin
					sel = window[j];
				end
			end
			byte_ok[i] = !used || cfg.wildcard_mask[i] || (sel == cfg.pattern[i]);
			if (used && !cfg.wildcard_mask[i]) begin
				all_wild = 1'b0;
			end
		end
	end

	// A pattern is unusable when empty, too long, or made only of wildcards.
	assign match.bad = (cfg.pattern_length == '0)
		|| (int'(cfg.pattern_length) > LEN_LIMIT) || all_wild;
	assign match.window_ok = &byte_ok;

endmodule

[rtl/core/wbps_tracker.sv]
module wbps_tracker
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  in_t                         item,
	input  cfg_t                        cfg,
	input  match_t                      match,
	output logic [PATTERN_MAX-1:0][7:0] window_next,
	output out_t                        result
);

	localparam int FILL_W = $clog2(PATTERN_MAX + 1);
	localparam int CMP_W  = FILL_W + LEN_W;

	logic [PATTERN_MAX-1:0][7:0] window_q;
	logic [OFFSET_BITS-1:0]      position_q;
	logic [FILL_W-1:0]           fill_q;
	logic [COUNT_W-1:0]          count_q;
	logic [OFFSET_BITS-1:0]      first_q;

	logic [FILL_W-1:0]      fill_next;
	logic                   hit;
	logic [OFFSET_BITS-1:0] hit_offset;
	logic [COUNT_W-1:0]     count_next;
	logic [OFFSET_BITS-1:0] first_next;
	logic [63:0]            first_wide;

	// Shift the new byte into the newest window slot.
	always_comb begin
		window_next[0] = item.data_byte;
		for (int j = 1; j < PATTERN_MAX; j++) begin
			window_next[j] = window_q[j-1];
		end
	end

	assign fill_next = (fill_q == FILL_W'(PATTERN_MAX)) ? fill_q : fill_q + 1'b1;
	assign hit = !match.bad && match.window_ok
		&& (CMP_W'(fill_next) >= CMP_W'(cfg.pattern_length));
	assign hit_offset = position_q + OFFSET_BITS'(1) - OFFSET_BITS'(cfg.pattern_length);
	assign count_next = (hit && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign first_next = (hit && count_q == '0) ? hit_offset : first_q;
	assign first_wide = 64'(first_next);

	// Region summary as it stands after this byte.
	always_comb begin
		result = '0;
		if (match.bad) begin
			result.status = STATUS_BAD;
		end else if (count_next == '0) begin
			result.status = STATUS_NOT_FOUND;
		end else if (count_next == COUNT_W'(1)) begin
			result.status       = STATUS_FOUND;
			result.first_offset = first_wide[RES_OFF_W-1:0];
			result.match_count  = count_next;
		end else begin
			result.status      = STATUS_AMBIGUOUS;
			result.match_count = count_next;
		end
	end

	// Region state; the last byte clears everything for the next region.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			position_q <= '0;
			fill_q     <= '0;
			count_q    <= '0;
			first_q    <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				window_q   <= '0;
				position_q <= '0;
				fill_q     <= '0;
				count_q    <= '0;
				first_q    <= '0;
			end else begin
				window_q   <= window_next;
				position_q <= position_q + 1'b1;
				fill_q     <= fill_next;
				count_q    <= count_next;
				first_q    <= first_next;
			end
		end
	end

endmodule

[rtl/core/wildcard_byte_pattern_scanner_unit.sv]
// Wildcard byte pattern scanner.
// The input channel (in_valid, in_ready, in_data) carries one byte of a memory
// region per transaction, with last_byte set on the final byte. The output
// channel (out_valid, out_ready, out_data) carries one summary per region:
// status, offset of a unique match, and the saturating match count.
// The pattern, wildcard mask and length are set through the APB port at byte
// addresses 0, 8, 16 and 24 (64-bit data); write them only while idle.
// Throughput is one byte per cycle while no last byte is held back, set by the
// combinational window compare between the input register and the tracker
// state. A last byte is held in the input register, and when it advances the
// compare writes the result register, which raises out_valid.
// When the receiver stalls, ordinary bytes keep flowing; a last byte waits in
// the input register until the result register is free, and in_ready drops
// only then.
// Reset clears the configuration, the window, the counters and both
// channel valid flags; no clearing pass is needed.
module wildcard_byte_pattern_scanner_unit
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t                        cfg;
	match_t                      match;
	logic [PATTERN_MAX-1:0][7:0] window_next;
	out_t                        result;

	logic valid_s1;
	in_t  item_s1;
	logic out_valid_q;
	out_t out_data_q;
	logic out_free;
	logic advance;

	wbps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wbps_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.window (window_next),
		.cfg    (cfg),
		.match  (match)
	);

	wbps_tracker #(
		.PATTERN_MAX (PATTERN_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.cfg         (cfg),
		.match       (match),
		.window_next (window_next),
		.result      (result)
	);

	// Only a last byte needs room in the result register.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!item_s1.last_byte || out_free);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A last byte must not pass while an untaken summary occupies the output.
	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last_byte && out_valid_q && !out_ready |=> valid_s1)
		else $error("last byte advanced over a stalled summary");

	// Input backpressure only comes from a held item.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && item_s1.last_byte && !out_free)
		else $error("input stalled without a waiting last byte");

	// A bad pattern never reports matches.
	a_bad_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status == STATUS_BAD
		|-> out_data_q.match_count == '0 && out_data_q.first_offset == '0)
		else $error("bad pattern summary carries matches");

	// A found status means exactly one match.
	a_found_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status == STATUS_FOUND
		|-> out_data_q.match_count == COUNT_W'(1))
		else $error("found status without a unique match");

endmodule
